// ===== hdl/sus_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sus_pkg;

  // Set size and derived widths.
  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int COUNT_W  = 6;
  localparam int DATA_W   = 32;

  // Action codes; any code with the high bit set lists the set.
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_LISTED    = 3'd5;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/sorted_unique_set_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                              Transfer
// command   start, action, value                               start && !busy
// result    strobe, status, count, element, element_valid,     strobe
//           last
//
// An insert or delete is accepted while idle; its single result appears on the
// next cycle and another command can be accepted at once.
// A listing of n stored values, n at least one: busy is high while the chain
// rotates once, one value per cycle read from its head, and each result shows
// in the cycle after its value is read, so the final one shows on the first
// idle cycle, when the next command can already be accepted.
// A listing of an empty set gives a single result.
// Reset clears the entry count and the control state; no memory clear.
// The receiver cannot stall: each result stands for exactly one cycle.

module sorted_unique_set_top
  import sus_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                action,
  input  wire logic signed [DATA_W-1:0]  value,
  output logic                           strobe,
  output logic [2:0]                     status,
  output logic [COUNT_W-1:0]             count,
  output logic signed [DATA_W-1:0]       element,
  output logic                           element_valid,
  output logic                           last
);

  typedef enum logic {
    IDLE,
    LIST
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         entry_count;
  logic [CNT_W-1:0]         entry_count_next;
  logic [CNT_W-1:0]         remaining;
  logic [2:0]               status_next;

  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic [CAPACITY-1:0]      cell_lt;
  logic [CAPACITY-1:0]      cell_eq;

  logic accept;
  logic found;
  logic full;
  logic do_insert;
  logic do_delete;

  assign busy   = (state != IDLE);
  assign accept = start && !busy;
  assign found  = |cell_eq;
  assign full   = (entry_count == CNT_W'(CAPACITY));

  assign do_insert = accept && (action == ACT_INSERT) && !found && !full;
  assign do_delete = accept && (action == ACT_DELETE) && found;

  // Broadcast operation for the chain.
  always_comb begin
    ctrl.key = value;
    if (state == LIST) begin
      ctrl.op = OP_ROTATE;
    end else if (do_insert) begin
      ctrl.op = OP_INSERT;
    end else if (do_delete) begin
      ctrl.op = OP_DELETE;
    end else begin
      ctrl.op = OP_HOLD;
    end
  end

  // Status and count for a single-result command.
  always_comb begin
    if (action == ACT_INSERT) begin
      status_next = found ? ST_DUPLICATE : (full ? ST_FULL : ST_INSERTED);
    end else begin
      status_next = found ? ST_DELETED : ST_NOT_FOUND;
    end
    if (do_insert) begin
      entry_count_next = entry_count + CNT_W'(1);
    end else if (do_delete) begin
      entry_count_next = entry_count - CNT_W'(1);
    end else begin
      entry_count_next = entry_count;
    end
  end

  // Chain of cells; the first cell sees an always-lower left neighbor,
  // the last one sees itself on the right.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     left_lt;
    logic signed [DATA_W-1:0] left_value;
    logic signed [DATA_W-1:0] right_value;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_value = value;
    end else begin : g_inner
      assign left_lt    = cell_lt[i-1];
      assign left_value = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = cell_value[i];
    end else begin : g_body
      assign right_value = cell_value[i+1];
    end

    sus_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (CNT_W'(i) < entry_count),
      .tail        (CNT_W'(i + 1) == entry_count),
      .left_lt     (left_lt),
      .left_value  (left_value),
      .right_value (right_value),
      .head_value  (cell_value[0]),
      .value       (cell_value[i]),
      .lt          (cell_lt[i]),
      .eq          (cell_eq[i])
    );
  end

  // Sequencer with registered result outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      strobe      <= 1'b0;
      entry_count <= '0;
      remaining   <= '0;
    end else begin
      strobe      <= 1'b0;
      entry_count <= entry_count_next;
      case (state)
        IDLE: begin
          if (accept) begin
            strobe        <= 1'b1;
            element       <= '0;
            element_valid <= 1'b0;
            last          <= 1'b1;
            count         <= COUNT_W'(entry_count_next);
            if (action[1]) begin
              status <= ST_LISTED;
              if (entry_count != '0) begin
                strobe    <= 1'b0;
                remaining <= entry_count;
                state     <= LIST;
              end
            end else begin
              status <= status_next;
            end
          end
        end
        LIST: begin
          strobe        <= 1'b1;
          status        <= ST_LISTED;
          element       <= cell_value[0];
          element_valid <= 1'b1;
          last          <= (remaining == CNT_W'(1));
          count         <= COUNT_W'(entry_count);
          remaining     <= remaining - CNT_W'(1);
          if (remaining == CNT_W'(1)) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The count never passes the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A result shown while idle is always the final one of its command.
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    strobe && !busy |-> last)
    else $error("non-final result while idle");

  // Only listings carry a stored element.
  a_valid_listed: assert property (@(posedge clk) disable iff (rst)
    strobe && element_valid |-> status == ST_LISTED)
    else $error("element marked valid outside a listing");

  // A successful insert grows the set by one.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    strobe && (status == ST_INSERTED) && $past(!rst) |->
      entry_count == CNT_W'($past(entry_count) + CNT_W'(1)))
    else $error("insert did not grow the set");

  // Outside a listing the head of the chain is in strict ascending order.
  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    !busy && (entry_count >= CNT_W'(2)) |-> cell_value[0] < cell_value[1])
    else $error("chain head out of order");

endmodule

`default_nettype wire

// ===== hdl/sus_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sus_cell
  import sus_pkg::*;
(
  input  wire logic                      clk,
  input  wire cell_ctrl_t                ctrl,
  input  wire logic                      occupied,
  input  wire logic                      tail,
  input  wire logic                      left_lt,
  input  wire logic signed [DATA_W-1:0]  left_value,
  input  wire logic signed [DATA_W-1:0]  right_value,
  input  wire logic signed [DATA_W-1:0]  head_value,
  output logic signed [DATA_W-1:0]       value,
  output logic                           lt,
  output logic                           eq
);

  // Compare the stored entry against the broadcast key.
  assign lt = occupied && (value < ctrl.key);
  assign eq = occupied && (value == ctrl.key);

  // Insert or delete: cells from the key's slot take key or neighbor.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (!lt) begin
          value <= left_lt ? ctrl.key : left_value;
        end
      end
      OP_DELETE: begin
        if (!lt) begin
          value <= right_value;
        end
      end
      OP_ROTATE: begin
        value <= tail ? head_value : right_value;
      end
      default: begin
        value <= value;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== test/tb_sorted_unique_set_top.sv =====
`timescale 1ns / 1ps

module tb_sorted_unique_set_top;
  import sus_pkg::*;

  // Listing codes: any action with the high bit set lists the set.
  localparam logic [1:0] ACT_LIST     = 2'd2;
  localparam logic [1:0] ACT_LIST_ALT = 2'd3;
  localparam int         ITEMS_PER_PHASE = 166;

  typedef struct packed {
    logic [2:0]               status;
    logic [COUNT_W-1:0]       count;
    logic signed [DATA_W-1:0] element;
    logic                     element_valid;
    logic                     last;
  } set_result_t;

  // Tracks the stored set and the results that the block still owes.
  class set_checker;
    logic signed [DATA_W-1:0] members[$];
    set_result_t              owed[$];
    int                       faults;

    function void owe(logic [2:0] st, logic signed [DATA_W-1:0] elem, logic vld, logic fin);
      set_result_t r;
      r.status        = st;
      r.count         = COUNT_W'(members.size());
      r.element       = elem;
      r.element_valid = vld;
      r.last          = fin;
      owed.push_back(r);
    endfunction

    function void flag(string what);
      faults++;
      if (faults <= 10) begin
        $display("%0t: %s", $realtime, what);
      end
    endfunction

    // Applies one accepted command to the set and queues its results.
    function void note_command(logic [1:0] act, logic signed [DATA_W-1:0] val);
      int  n;
      int  pos;
      bit  hit;
      n   = members.size();
      pos = 0;
      while (pos < n && members[pos] < val) pos++;
      hit = (pos < n) && (members[pos] == val);
      if (act == ACT_INSERT) begin
        if (hit) begin
          owe(ST_DUPLICATE, '0, 1'b0, 1'b1);
        end else if (n >= CAPACITY) begin
          owe(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          members.insert(pos, val);
          owe(ST_INSERTED, '0, 1'b0, 1'b1);
        end
      end else if (act == ACT_DELETE) begin
        if (hit) begin
          members.delete(pos);
          owe(ST_DELETED, '0, 1'b0, 1'b1);
        end else begin
          owe(ST_NOT_FOUND, '0, 1'b0, 1'b1);
        end
      end else if (n == 0) begin
        owe(ST_LISTED, '0, 1'b0, 1'b1);
      end else begin
        for (int i = 0; i < n; i++) owe(ST_LISTED, members[i], 1'b1, i == n - 1);
      end
    endfunction

    // Compares one result transfer with the oldest owed result.
    function void check_result(set_result_t got);
      set_result_t want;
      if (owed.size() == 0) begin
        flag($sformatf("unexpected result: status %0d count %0d element %0d valid %0b last %0b",
                       got.status, got.count, got.element, got.element_valid, got.last));
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        flag($sformatf({"result mismatch: expected status %0d count %0d element %0d ",
                        "valid %0b last %0b, got status %0d count %0d element %0d ",
                        "valid %0b last %0b"},
                       want.status, want.count, want.element, want.element_valid, want.last,
                       got.status, got.count, got.element, got.element_valid, got.last));
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [1:0]               action;
  logic signed [DATA_W-1:0] value;
  logic                     strobe;
  logic [2:0]               status;
  logic [COUNT_W-1:0]       count;
  logic signed [DATA_W-1:0] element;
  logic                     element_valid;
  logic                     last;

  set_checker chk = new();

  sorted_unique_set_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .action        (action),
    .value         (value),
    .strobe        (strobe),
    .status        (status),
    .count         (count),
    .element       (element),
    .element_valid (element_valid),
    .last          (last)
  );

  always #4 clk = ~clk;

  // Results are checked before the command accepted at the same edge is applied.
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        chk.check_result('{status, count, element, element_valid, last});
      end
      if (start && !busy) begin
        chk.note_command(action, value);
      end
    end
  end

  // Presents one command after a random gap and waits for its transfer.
  task automatic send_command(input logic [1:0] act, input logic signed [DATA_W-1:0] val,
                              input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start  <= 1'b0;
      action <= 2'($urandom);
      value  <= $urandom;
      @(posedge clk);
    end
    start  <= 1'b1;
    action <= act;
    value  <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Holds the command port idle until every owed result has arrived.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (chk.owed.size() != 0) @(posedge clk);
  endtask

  // Picks a value: often one already stored, else a small, extreme or full-range value.
  function automatic logic signed [DATA_W-1:0] pick_value(int stored_pct);
    logic signed [DATA_W-1:0] v;
    int                       s;
    s = $urandom_range(0, 99);
    if (s < stored_pct && chk.members.size() > 0) begin
      v = chk.members[$urandom_range(0, chk.members.size() - 1)];
    end else if (s < stored_pct + 20) begin
      v = $urandom_range(0, 16);
      v = v - 8;
    end else if (s < stored_pct + 30) begin
      case ($urandom_range(0, 4))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7fff_ffff;
        2: v = -1;
        3: v = 0;
        default: v = 1;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Random command mix, weighted toward growing the set or toward draining it.
  task automatic random_command(input bit filling, output logic [1:0] act,
                                output logic signed [DATA_W-1:0] val);
    int r;
    r = $urandom_range(0, 99);
    if (r < (filling ? 70 : 15)) begin
      act = ACT_INSERT;
      val = pick_value(filling ? 30 : 40);
    end else if (r < 85) begin
      act = ACT_DELETE;
      val = pick_value(filling ? 50 : 70);
    end else begin
      act = $urandom_range(0, 1) ? ACT_LIST : ACT_LIST_ALT;
      val = $urandom;
    end
  endtask

  int idle_plan[3] = '{38, 64, 0};

  initial begin
    logic [1:0]               act;
    logic signed [DATA_W-1:0] val;
    rst    <= 1'b1;
    start  <= 1'b0;
    action <= ACT_INSERT;
    value  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty set, extremes, duplicates, misses and both listing codes.
    send_command(ACT_LIST, 32'sd77, 0);
    send_command(ACT_DELETE, 32'sd5, 0);
    send_command(ACT_INSERT, 32'sd0, 0);
    send_command(ACT_INSERT, 32'sh7fff_ffff, 0);
    send_command(ACT_INSERT, 32'sh8000_0000, 0);
    send_command(ACT_INSERT, -32'sd1, 0);
    send_command(ACT_INSERT, 32'sd1, 0);
    send_command(ACT_INSERT, 32'sd0, 0);
    send_command(ACT_LIST_ALT, -32'sd1, 0);
    send_command(ACT_DELETE, 32'sh7fff_ffff, 0);
    send_command(ACT_DELETE, 32'sh7fff_ffff, 0);
    send_command(ACT_DELETE, 32'sh8000_0000, 0);
    send_command(ACT_INSERT, 32'sh5555_5555, 0);
    send_command(ACT_INSERT, 32'shaaaa_aaaa, 0);
    send_command(ACT_LIST, 32'sd0, 0);
    send_command(ACT_DELETE, -32'sd1, 0);
    send_command(ACT_DELETE, 32'sd0, 0);
    send_command(ACT_DELETE, 32'sd1, 0);
    send_command(ACT_DELETE, 32'sh5555_5555, 0);
    send_command(ACT_DELETE, 32'shaaaa_aaaa, 0);
    send_command(ACT_LIST_ALT, 32'sd0, 0);
    drain_results();

    // Random phases with differing sender gaps; the set is filled and drained in turns.
    foreach (idle_plan[p]) begin
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        random_command(((k / 60) % 2) == 0, act, val);
        send_command(act, val, idle_plan[p]);
      end
      drain_results();
    end

    repeat (40) @(posedge clk);
    if (chk.faults == 0 && chk.owed.size() == 0) begin
      $display("sorted_unique_set_top verification clean");
    end else begin
      $display("sorted_unique_set_top verification failed");
    end
    $finish;
  end

  // Ends a hung run.
  initial begin
    #5ms;
    $display("sorted_unique_set_top verification failed");
    $finish;
  end

endmodule
